/* rtl/dofp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dofp_pkg: shared types and constants
// Fingerprint table, word types and the front/back queue entry format.
// ----------------------------------------------------------------------------
package dofp_pkg;

  localparam int unsigned TableRows = 13;
  localparam int unsigned PatMax    = 21;

  localparam logic [7:0] OptPad      = 8'd0;
  localparam logic [7:0] OptEnd      = 8'd255;
  localparam logic [7:0] OptHostName = 8'd12;
  localparam logic [7:0] OptOverload = 8'd52;
  localparam logic [7:0] OptMsgType  = 8'd53;
  localparam logic [7:0] OptParamReq = 8'd55;
  localparam logic [7:0] OptVendor   = 8'd60;
  localparam logic [7:0] MsgRequest  = 8'd3;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2
  } tlv_phase_e;

  typedef enum logic [1:0] {
    REG_OPTIONS = 2'd0,
    REG_FILE    = 2'd1,
    REG_SNAME   = 2'd2
  } region_e;

  typedef struct packed {
    logic [7:0] code;
    logic [4:0] len;
    logic [3:0] cls;
  } fp_head_t;

  // One queue entry: up to one name character and optionally a summary.
  typedef struct packed {
    logic       has_char;
    logic [7:0] name_char;
    logic [6:0] name_index;
    logic       has_sum;
    logic [3:0] os_class;
    logic       os_class_valid;
    logic       request_seen;
    logic       name_valid;
    logic [6:0] name_length;
    logic       stopped_early;
  } entry_t;

  function automatic fp_head_t fp_head(input logic [3:0] row);
    fp_head_t h;
    case (row)
      4'd0:    h = '{8'd55, 5'd6, 4'd1};
      4'd1:    h = '{8'd60, 5'd13, 4'd2};
      4'd2:    h = '{8'd60, 5'd10, 4'd3};
      4'd3:    h = '{8'd55, 5'd12, 4'd4};
      4'd4:    h = '{8'd55, 5'd11, 4'd5};
      4'd5:    h = '{8'd60, 5'd21, 4'd6};
      4'd6:    h = '{8'd55, 5'd7, 4'd7};
      4'd7:    h = '{8'd55, 5'd10, 4'd8};
      4'd8:    h = '{8'd55, 5'd9, 4'd9};
      4'd9:    h = '{8'd55, 5'd7, 4'd10};
      4'd10:   h = '{8'd55, 5'd9, 4'd11};
      4'd11:   h = '{8'd55, 5'd13, 4'd12};
      4'd12:   h = '{8'd55, 5'd13, 4'd12};
      default: h = '{8'd0, 5'd0, 4'd0};
    endcase
    return h;
  endfunction

  // Pattern byte of a row at a value position; only read below the row length.
  // Each row is held first byte highest, padded with zero bytes at the bottom.
  function automatic logic [7:0] fp_pat(input logic [3:0] row, input logic [4:0] idx);
    logic [PatMax*8-1:0] v;
    int unsigned lo;
    case (row)
      4'd0: v = {8'h01,8'h03,8'h06,8'h0F,8'h77,8'hFC,{15{8'h00}}};
      4'd1: v = {8'h64,8'h68,8'h63,8'h70,8'h63,8'h64,8'h20,8'h34,8'h2E,8'h30,
                 8'h2E,8'h31,8'h35,{8{8'h00}}};
      4'd2: v = {8'h42,8'h6C,8'h61,8'h63,8'h6B,8'h42,8'h65,8'h72,8'h72,8'h79,
                 {11{8'h00}}};
      4'd3: v = {8'h01,8'h0f,8'h03,8'h06,8'h2c,8'h2e,8'h2f,8'h1f,8'h21,8'h79,
                 8'hf9,8'h2b,{9{8'h00}}};
      4'd4: v = {8'h01,8'h0f,8'h03,8'h06,8'h2c,8'h2e,8'h2f,8'h1f,8'h21,8'hf9,
                 8'h2b,{10{8'h00}}};
      4'd5: v = {8'h4d,8'h69,8'h63,8'h72,8'h6f,8'h73,8'h6f,8'h66,8'h74,8'h20,8'h57,
                 8'h69,8'h6e,8'h64,8'h6f,8'h77,8'h73,8'h20,8'h43,8'h45,8'h00};
      4'd6: v = {8'h01,8'h03,8'h06,8'h0f,8'h2c,8'h2e,8'h2f,{14{8'h00}}};
      4'd7: v = {8'h01,8'h03,8'h06,8'h0f,8'h77,8'h5f,8'hfc,8'h2c,8'h2e,8'h2f,
                 {11{8'h00}}};
      4'd8: v = {8'h01,8'h03,8'h06,8'h0f,8'h77,8'h5f,8'hfc,8'h2c,8'h2e,{12{8'h00}}};
      4'd9: v = {8'h01,8'h79,8'h03,8'h06,8'h0F,8'h77,8'hFC,{14{8'h00}}};
      4'd10: v = {8'h01,8'h21,8'h03,8'h06,8'h0f,8'h1c,8'h33,8'h3a,8'h3b,{12{8'h00}}};
      4'd11: v = {8'h01,8'h0f,8'h03,8'h06,8'h2c,8'h2e,8'h2f,8'h1f,8'h21,8'h79,
                  8'hf9,8'hfc,8'h2b,{8{8'h00}}};
      4'd12: v = {8'h01,8'h03,8'h06,8'h0f,8'h1f,8'h21,8'h2b,8'h2c,8'h2e,8'h2f,
                  8'h79,8'hf9,8'hfc,{8{8'h00}}};
      default: v = '0;
    endcase
    lo = (idx < 5'(PatMax)) ? 8 * (PatMax - 1 - 32'(idx)) : 0;
    return (idx < 5'(PatMax)) ? v[lo +: 8] : 8'h00;
  endfunction

endpackage

/* rtl/dhcp_option_fingerprint_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_fingerprint_parse: DHCP option walker with client fingerprint
// Walks options, overloaded file and server-name regions, emits host-name
// characters and an end-of-message summary.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the result queue has room.
// Each result word is read from a queue entry registered from its input word.
// An input word carrying both a name character and a summary yields a name
// word and then a summary word; up to two queued entries absorb these and output stalls.
// Reset (rst_ni low, asynchronous) clears all parse state and the queue.
module dhcp_option_fingerprint_parse #(
  parameter int unsigned OPTIONS_BYTES = 308,
  parameter int unsigned NAME_LIMIT    = 128,
  parameter int unsigned FINGERPRINTS  = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] data_byte, [9:8] region, [10] first_of_message,
  // [11] last_of_message, [12] is_bootrequest, [13] node_started
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] result_kind, [8:1] name_char, [15:9] name_index, [19:16] os_class,
  // [20] os_class_valid, [21] request_seen, [22] name_valid,
  // [29:23] name_length, [30] stopped_early
  output logic [31:0] m_axis_tdata
);

  logic push, empty, afull, pop, accept;
  dofp_pkg::entry_t fe, qe;

  // Back-pressure is taken from an almost-full mark, so a word is never lost.
  assign s_axis_tready = !afull;
  assign accept = s_axis_tvalid && s_axis_tready;

  dofp_front #(
    .OPTIONS_BYTES(OPTIONS_BYTES), .NAME_LIMIT(NAME_LIMIT), .FINGERPRINTS(FINGERPRINTS)
  ) u_front (
    .clk_i, .rst_ni, .valid_i(accept),
    .data_byte_i(s_axis_tdata[7:0]), .region_i(s_axis_tdata[9:8]),
    .first_i(s_axis_tdata[10]), .last_i(s_axis_tdata[11]),
    .boot_i(s_axis_tdata[12]), .started_i(s_axis_tdata[13]),
    .push_o(push), .entry_o(fe)
  );

  dofp_queue #(.DEPTH(4)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fe), .pop_i(pop),
    .empty_o(empty), .afull_o(afull), .data_o(qe)
  );

  dofp_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .entry_i(qe), .pop_o(pop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(m_axis_tdata)
  );

  logic unused_hi;
  assign unused_hi = |s_axis_tdata[15:14];

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    afull |-> !accept) else $error("word accepted while queue almost full");
  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue popped while empty");
  a_summary_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[30:16] == '0))
    else $error("summary fields set in a name word");

endmodule

/* rtl/dofp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dofp_front: option walker
// Accepts message bytes, walks the TLV options and builds queue entries.
// ----------------------------------------------------------------------------
module dofp_front #(
  parameter int unsigned OPTIONS_BYTES = 308,
  parameter int unsigned NAME_LIMIT    = 128,
  parameter int unsigned FINGERPRINTS  = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [7:0]          data_byte_i,
  input  logic [1:0]          region_i,
  input  logic                first_i,
  input  logic                last_i,
  input  logic                boot_i,
  input  logic                started_i,
  output logic                push_o,
  output dofp_pkg::entry_t    entry_o
);

  localparam int unsigned Rows  = (FINGERPRINTS < dofp_pkg::TableRows) ?
                                  FINGERPRINTS : dofp_pkg::TableRows;
  localparam int unsigned PosW  = $clog2(OPTIONS_BYTES + 257);
  localparam int unsigned FileBytes  = 128;
  localparam int unsigned SnameBytes = 64;

  logic [PosW-1:0] pos_q, pos_d;
  dofp_pkg::tlv_phase_e phase_q, phase_d;
  logic [7:0] code_q, code_d, left_q, left_d, vidx_q, vidx_d;
  logic [1:0] ovl_q, ovl_d, act_q, act_d;
  logic done_q, done_d;
  logic [Rows-1:0] alive_q, alive_d;
  logic [3:0] os_q, os_d;
  logic [3:0] flags_q, flags_d;
  logic [6:0] hlen_q, hlen_d;

  logic [PosW-1:0] c_pos, size;
  dofp_pkg::tlv_phase_e c_phase;
  logic [7:0] c_code, c_left, c_vidx, b;
  logic [1:0] c_ovl, c_act;
  logic c_done, fp_opt;
  logic [Rows-1:0] c_alive;
  logic [3:0] c_os, c_flags;
  logic [6:0] c_hlen;
  logic [8:0] total;
  logic       c_has_char;
  logic [7:0] c_char;
  logic [6:0] c_cidx;

  function automatic logic [PosW-1:0] rsize(input logic [1:0] r);
    logic [PosW-1:0] s;
    case (r)
      dofp_pkg::REG_OPTIONS: s = PosW'(OPTIONS_BYTES);
      dofp_pkg::REG_FILE:    s = PosW'(FileBytes);
      dofp_pkg::REG_SNAME:   s = PosW'(SnameBytes);
      default:               s = '0;
    endcase
    return s;
  endfunction

  always_comb begin
    b = data_byte_i;
    if (first_i) begin
      c_pos = '0; c_phase = dofp_pkg::PH_CODE; c_code = '0; c_left = '0; c_vidx = '0;
      c_ovl = '0; c_act = dofp_pkg::REG_OPTIONS; c_done = 1'b0; c_alive = '0;
      c_os = '0; c_flags = '0; c_hlen = '0;
    end else begin
      c_pos = pos_q; c_phase = phase_q; c_code = code_q; c_left = left_q;
      c_vidx = vidx_q; c_ovl = ovl_q; c_act = act_q; c_done = done_q;
      c_alive = alive_q; c_os = os_q; c_flags = flags_q; c_hlen = hlen_q;
    end
    pos_d = c_pos; phase_d = c_phase; code_d = c_code; left_d = c_left;
    vidx_d = c_vidx; ovl_d = c_ovl; act_d = c_act; done_d = c_done;
    alive_d = c_alive; os_d = c_os; flags_d = c_flags; hlen_d = c_hlen;
    size = rsize(c_act);
    fp_opt = (c_code == dofp_pkg::OptParamReq) || (c_code == dofp_pkg::OptVendor);
    total = {1'b0, c_vidx} + {1'b0, c_left};
    c_has_char = 1'b0;
    c_char = '0;
    c_cidx = '0;

    if (boot_i && !started_i && !c_done && region_i == c_act) begin
      if (c_pos >= size) begin
        done_d = 1'b1;
      end else begin
        pos_d = c_pos + 1'b1;
        case (c_phase)
          dofp_pkg::PH_CODE: begin
            if (b == dofp_pkg::OptEnd) begin
              if (c_act == dofp_pkg::REG_OPTIONS && c_ovl[0]) begin
                act_d = dofp_pkg::REG_FILE; pos_d = '0;
              end else if (c_act == dofp_pkg::REG_FILE && c_ovl[1]) begin
                act_d = dofp_pkg::REG_SNAME; pos_d = '0;
              end else begin
                done_d = 1'b1;
              end
            end else if (b != dofp_pkg::OptPad) begin
              code_d = b; phase_d = dofp_pkg::PH_LEN;
              if (c_pos + 1'b1 >= size) begin
                flags_d[3] = 1'b1; done_d = 1'b1;
              end
            end
          end
          dofp_pkg::PH_LEN: begin
            if (c_pos + 1'b1 + PosW'(b) > size) begin
              flags_d[3] = 1'b1; done_d = 1'b1;
            end else begin
              if (fp_opt) begin
                for (int k = 0; k < Rows; k++) begin
                  alive_d[k] = (dofp_pkg::fp_head(4'(k)).code == c_code) &&
                               (b >= {3'b0, dofp_pkg::fp_head(4'(k)).len});
                end
              end else if (c_code == dofp_pkg::OptHostName &&
                           {1'b0, b} < 9'(NAME_LIMIT)) begin
                flags_d[2] = 1'b1;
                hlen_d = b[7] ? 7'd127 : b[6:0];
              end
              if (b == 8'd0) begin
                phase_d = dofp_pkg::PH_CODE;
                if (fp_opt) begin
                  os_d = 4'd0; flags_d[0] = 1'b1; alive_d = '0;
                end
              end else begin
                left_d = b; vidx_d = '0; phase_d = dofp_pkg::PH_VAL;
              end
            end
          end
          dofp_pkg::PH_VAL: begin
            if (c_code == dofp_pkg::OptMsgType) begin
              if (total == 9'd1 && b == dofp_pkg::MsgRequest) flags_d[1] = 1'b1;
            end else if (c_code == dofp_pkg::OptOverload) begin
              if (c_vidx == 8'd0) ovl_d = b[1:0];
            end else if (fp_opt) begin
              for (int k = 0; k < Rows; k++) begin
                if (c_alive[k] && c_vidx < {3'b0, dofp_pkg::fp_head(4'(k)).len} &&
                    dofp_pkg::fp_pat(4'(k), c_vidx[4:0]) != b)
                  alive_d[k] = 1'b0;
              end
            end else if (c_code == dofp_pkg::OptHostName && total < 9'(NAME_LIMIT)) begin
              c_has_char = 1'b1;
              c_char = b;
              c_cidx = c_vidx[7] ? 7'd127 : c_vidx[6:0];
            end
            if (c_left != 8'd0) left_d = c_left - 1'b1;
            vidx_d = c_vidx + 1'b1;
            if (c_left <= 8'd1) begin
              phase_d = dofp_pkg::PH_CODE;
              if (fp_opt) begin
                // The class itself is folded from the updated survivors below.
                os_d = 4'd0; flags_d[0] = 1'b1;
              end
            end
          end
          default: phase_d = dofp_pkg::PH_CODE;
        endcase
        if (!done_d && phase_d == dofp_pkg::PH_CODE && pos_d >= rsize(act_d))
          done_d = 1'b1;
      end
    end
  end

  // The class of a finished fingerprint option is the first surviving row of
  // the updated mask, resolved in the same cycle as the option's last byte.
  logic fin_d;
  logic [3:0] os_eff, first_cls_d;
  logic [Rows-1:0] fin_mask;
  logic [Rows-1:0] alive_upd;

  always_comb begin
    fin_d = 1'b0;
    fin_mask = alive_d;
    if (valid_i && boot_i && !started_i && !c_done && region_i == c_act &&
        c_pos < size && c_phase == dofp_pkg::PH_VAL && c_left <= 8'd1 && fp_opt)
      fin_d = 1'b1;
    first_cls_d = 4'd0;
    for (int k = Rows - 1; k >= 0; k--) begin
      if (fin_mask[k]) first_cls_d = dofp_pkg::fp_head(4'(k)).cls;
    end
    alive_upd = fin_d ? '0 : alive_d;
    os_eff = fin_d ? first_cls_d : os_d;
  end

  always_comb begin
    entry_o = '0;
    entry_o.has_char = c_has_char;
    entry_o.name_char = c_char;
    entry_o.name_index = c_cidx;
    entry_o.has_sum = last_i;
    entry_o.os_class = os_eff;
    entry_o.os_class_valid = flags_d[0];
    entry_o.request_seen = flags_d[1];
    entry_o.name_valid = flags_d[2];
    entry_o.name_length = hlen_d;
    entry_o.stopped_early = flags_d[3];
    push_o = valid_i && (c_has_char || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; phase_q <= dofp_pkg::PH_CODE; code_q <= '0; left_q <= '0;
      vidx_q <= '0; ovl_q <= '0; act_q <= dofp_pkg::REG_OPTIONS; done_q <= 1'b0;
      alive_q <= '0; os_q <= '0; flags_q <= '0; hlen_q <= '0;
    end else if (valid_i) begin
      pos_q <= pos_d; phase_q <= phase_d; code_q <= code_d; left_q <= left_d;
      vidx_q <= vidx_d; ovl_q <= ovl_d; act_q <= act_d; done_q <= done_d;
      alive_q <= alive_upd; os_q <= os_eff; flags_q <= flags_d; hlen_q <= hlen_d;
    end
  end

endmodule

/* rtl/dofp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dofp_queue: entry queue
// Small FIFO of register slots between the option walker and the emitter.
// ----------------------------------------------------------------------------
module dofp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dofp_pkg::entry_t data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             afull_o,
  output dofp_pkg::entry_t data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dofp_pkg::entry_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign afull_o = (cnt_q >= (AW+1)'(DEPTH - 2));
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule

/* rtl/dofp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dofp_back: result emitter
// Emits each queue entry as a name character word, a summary word, or both in that order.
// ----------------------------------------------------------------------------
module dofp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  dofp_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [31:0]      data_o
);

  logic sent_char_q, sent_char_d;
  logic want_char, last_part;

  assign want_char = entry_i.has_char && !sent_char_q;
  assign last_part = !want_char || !entry_i.has_sum;
  assign valid_o   = !empty_i;
  assign pop_o     = valid_o && ready_i && last_part;

  always_comb begin
    sent_char_d = sent_char_q;
    if (valid_o && ready_i) sent_char_d = !last_part;
    data_o = '0;
    if (want_char) begin
      data_o[8:1]  = entry_i.name_char;
      data_o[15:9] = entry_i.name_index;
    end else begin
      data_o[0]     = 1'b1;
      data_o[19:16] = entry_i.os_class;
      data_o[20]    = entry_i.os_class_valid;
      data_o[21]    = entry_i.request_seen;
      data_o[22]    = entry_i.name_valid;
      data_o[29:23] = entry_i.name_length;
      data_o[30]    = entry_i.stopped_early;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sent_char_q <= 1'b0;
    else         sent_char_q <= sent_char_d;
  end

endmodule
